[src/tqdg_pkg.sv]
// shared types, constants and rounding function for the two-qubit diagonal gate block
package tqdg_pkg;

    // width of the global amplitude index; bits at or above it read as zero
    localparam int INDEX_BITS = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_00   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_01   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_10   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_11   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_POS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX = 3'd6;

    localparam logic [63:0] COEFF_RESET      = 64'h0000_0000_4000_0000;
    localparam logic [4:0]  FIRST_POS_RESET  = 5'd0;
    localparam logic [4:0]  SECOND_POS_RESET = 5'd1;

    // half an lsb of q2.30 expressed in q4.60
    localparam logic signed [64:0] ROUND_HALF = 65'sd536870912;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [31:0] amp_re;
        logic signed [31:0] amp_im;
        logic signed [31:0] coef_re;
        logic signed [31:0] coef_im;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } t_round;

    // floor(s + 1/2) down to q2.30, clipped to the 32-bit range
    function automatic t_round round_sat(input logic signed [64:0] s);
        logic signed [64:0] t;
        logic [34:0]        r;
        t_round             res;
        t = s + ROUND_HALF;
        r = t[64:30];
        if ((r[34:31] == 4'b0000) || (r[34:31] == 4'b1111)) begin
            res.value = r[31:0];
            res.sat   = 1'b0;
        end else begin
            res.value = r[34] ? Q_MIN : Q_MAX;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

endpackage

[src/tqdg_amp_if.sv]
// amplitude input channel
interface tqdg_amp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] amp_re;
    logic signed [31:0] amp_im;
    logic               last_amp;

    modport source (output valid, output amp_re, output amp_im, output last_amp, input ready);
    modport sink   (input valid, input amp_re, input amp_im, input last_amp, output ready);
endinterface

[src/tqdg_res_if.sv]
// scaled amplitude result channel
interface tqdg_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               out_last;
    logic               saturated;

    modport source (output valid, output out_re, output out_im, output out_last,
                    output saturated, input ready);
    modport sink   (input valid, input out_re, input out_im, input out_last,
                    input saturated, output ready);
endinterface

[src/two_qubit_diagonal_gate_apply.sv]
// top level: two-qubit diagonal gate applied to a streamed amplitude slice
//
//  channel    dir  handshake            beat contents
//  i_amp_ch   in   valid / ready        amp_re, amp_im, last_amp
//  o_res_ch   out  valid / ready        out_re, out_im, out_last, saturated
//  i_cfg_*    in   i_cfg_we, no ready   register index, 64-bit write data
//
// one beat accepted and one delivered per cycle when the output is not stalled
// an input beat passes through the queue, the product register, the sum register
// and, after rounding, the output register
// synchronous reset restores the register defaults, clears the running index,
// the queue and the pipeline valids
// a stalled output freezes the multiply pipeline; the 4-entry queue keeps taking beats until it is full
module two_qubit_diagonal_gate_apply (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tqdg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tqdg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tqdg_amp_if.sink                          i_amp_ch,
    tqdg_res_if.source                        o_res_ch
);

    tqdg_pkg::t_cfg_wr cfg;
    logic              push_vld;
    logic              push_rdy;
    tqdg_pkg::t_item   push_item;
    logic              pop_vld;
    logic              pop_rdy;
    tqdg_pkg::t_item   pop_item;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    tqdg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_amp       (i_amp_ch),
        .o_push_vld  (push_vld),
        .i_push_rdy  (push_rdy),
        .o_push_item (push_item)
    );

    tqdg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (push_vld),
        .o_push_rdy  (push_rdy),
        .i_push_item (push_item),
        .o_pop_vld   (pop_vld),
        .i_pop_rdy   (pop_rdy),
        .o_pop_item  (pop_item)
    );

    tqdg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_vld  (pop_vld),
        .o_pop_rdy  (pop_rdy),
        .i_pop_item (pop_item),
        .o_res      (o_res_ch)
    );

endmodule

[src/tqdg_front.sv]
// front end: configuration registers, running index and coefficient selection
module tqdg_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tqdg_pkg::t_cfg_wr i_cfg,
    tqdg_amp_if.sink         i_amp,
    output logic             o_push_vld,
    input  logic             i_push_rdy,
    output tqdg_pkg::t_item  o_push_item
);

    logic [63:0] r_coeff [4];
    logic [4:0]  r_first_pos;
    logic [4:0]  r_second_pos;
    logic [31:0] r_base_index;
    logic [31:0] r_local_index;
    logic [31:0] n_local_index;

    logic [31:0] gidx;
    logic        b1;
    logic        b2;
    logic [1:0]  sel;
    logic        accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_coeff[k] <= tqdg_pkg::COEFF_RESET;
            end
            r_first_pos  <= tqdg_pkg::FIRST_POS_RESET;
            r_second_pos <= tqdg_pkg::SECOND_POS_RESET;
            r_base_index <= '0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                tqdg_pkg::CFG_COEFF_00:   r_coeff[0]   <= i_cfg.data;
                tqdg_pkg::CFG_COEFF_01:   r_coeff[1]   <= i_cfg.data;
                tqdg_pkg::CFG_COEFF_10:   r_coeff[2]   <= i_cfg.data;
                tqdg_pkg::CFG_COEFF_11:   r_coeff[3]   <= i_cfg.data;
                tqdg_pkg::CFG_FIRST_POS:  r_first_pos  <= i_cfg.data[4:0];
                tqdg_pkg::CFG_SECOND_POS: r_second_pos <= i_cfg.data[4:0];
                tqdg_pkg::CFG_BASE_INDEX: r_base_index <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    assign accept = i_amp.valid && i_push_rdy;

    always_comb begin
        n_local_index = r_local_index;
        if (accept) begin
            n_local_index = i_amp.last_amp ? 32'd0 : r_local_index + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_index <= '0;
        end else begin
            r_local_index <= n_local_index;
        end
    end

    // the carry out of the sum lies above every selectable bit
    assign gidx = r_base_index + r_local_index;
    assign b1   = gidx[r_first_pos]  && (int'(r_first_pos)  < tqdg_pkg::INDEX_BITS);
    assign b2   = gidx[r_second_pos] && (int'(r_second_pos) < tqdg_pkg::INDEX_BITS);
    assign sel  = {b1, b2};

    assign i_amp.ready          = i_push_rdy;
    assign o_push_vld           = i_amp.valid;
    assign o_push_item.amp_re   = i_amp.amp_re;
    assign o_push_item.amp_im   = i_amp.amp_im;
    assign o_push_item.coef_re  = r_coeff[sel][63:32];
    assign o_push_item.coef_im  = r_coeff[sel][31:0];
    assign o_push_item.last     = i_amp.last_amp;

endmodule

[src/tqdg_queue.sv]
// short queue between the front end and the multiply pipeline
module tqdg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_vld,
    output logic            o_push_rdy,
    input  tqdg_pkg::t_item i_push_item,
    output logic            o_pop_vld,
    input  logic            i_pop_rdy,
    output tqdg_pkg::t_item o_pop_item
);

    tqdg_pkg::t_item                 r_mem [tqdg_pkg::QUEUE_DEPTH];
    logic [tqdg_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [tqdg_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [tqdg_pkg::QUEUE_PTR_W:0]   r_count;
    logic                            push;
    logic                            pop;

    assign o_push_rdy = (r_count != (tqdg_pkg::QUEUE_PTR_W+1)'(tqdg_pkg::QUEUE_DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop_rdy && o_pop_vld;
    assign o_pop_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/tqdg_back.sv]
// back end: complex multiply, rounding and saturation, output register
module tqdg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_vld,
    output logic            o_pop_rdy,
    input  tqdg_pkg::t_item i_pop_item,
    tqdg_res_if.source      o_res
);

    logic en;

    logic               r_s1_vld;
    logic               r_s1_last;
    logic signed [63:0] r_prod_rr;
    logic signed [63:0] r_prod_ii;
    logic signed [63:0] r_prod_ri;
    logic signed [63:0] r_prod_ir;

    logic               r_s2_vld;
    logic               r_s2_last;
    logic signed [64:0] r_sum_re;
    logic signed [64:0] r_sum_im;

    logic               r_out_vld;
    logic [31:0]        r_out_re;
    logic [31:0]        r_out_im;
    logic               r_out_last;
    logic               r_out_sat;

    tqdg_pkg::t_round   rnd_re;
    tqdg_pkg::t_round   rnd_im;

    // whole pipeline moves together whenever the output register is empty or its beat is taken
    assign en        = !r_out_vld || o_res.ready;
    assign o_pop_rdy = en;

    assign rnd_re = tqdg_pkg::round_sat(r_sum_re);
    assign rnd_im = tqdg_pkg::round_sat(r_sum_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= i_pop_vld;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_rr  <= i_pop_item.amp_re * i_pop_item.coef_re;
            r_prod_ii  <= i_pop_item.amp_im * i_pop_item.coef_im;
            r_prod_ri  <= i_pop_item.amp_re * i_pop_item.coef_im;
            r_prod_ir  <= i_pop_item.amp_im * i_pop_item.coef_re;
            r_s1_last  <= i_pop_item.last;

            // exact q4.60 sums, one bit of headroom
            r_sum_re   <= 65'(r_prod_rr) - 65'(r_prod_ii);
            r_sum_im   <= 65'(r_prod_ri) + 65'(r_prod_ir);
            r_s2_last  <= r_s1_last;

            r_out_re   <= rnd_re.value;
            r_out_im   <= rnd_im.value;
            r_out_sat  <= rnd_re.sat || rnd_im.sat;
            r_out_last <= r_s2_last;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.out_re    = r_out_re;
    assign o_res.out_im    = r_out_im;
    assign o_res.out_last  = r_out_last;
    assign o_res.saturated = r_out_sat;

endmodule

[tb/two_qubit_diagonal_gate_apply_test.sv]
// testbench for the two-qubit diagonal gate block: directed and random slices checked beat by beat
`timescale 1ns / 1ps

module two_qubit_diagonal_gate_apply_test;

    // index above the register list, writes to it must change nothing
    localparam logic [tqdg_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int PHASES          = 8;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 750000;

    localparam logic signed [65:0] ROUND_BIAS = 66'sd536870912;
    localparam logic signed [65:0] Q230_TOP   = 66'sd2147483647;
    localparam logic signed [65:0] Q230_FLOOR = -66'sd2147483648;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
        logic               clipped;
    } t_scaled_amp;

    typedef struct packed {
        logic [31:0] value;
        logic        clipped;
    } t_q230;

    logic i_clk;
    logic i_rst_n;
    logic                            i_cfg_we;
    logic [tqdg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tqdg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tqdg_amp_if amp_ch ();
    tqdg_res_if res_ch ();

    two_qubit_diagonal_gate_apply dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_amp_ch    (amp_ch),
        .o_res_ch    (res_ch)
    );

    // shadow of the gate configuration and the running slice position
    logic [63:0] gate_entry [4];
    logic [4:0]  first_bit_pos;
    logic [4:0]  second_bit_pos;
    logic [31:0] slice_base;
    logic [31:0] slice_pos;

    t_scaled_amp pending_amps [$];
    t_scaled_amp want_amp;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          amp_gaps_on    = 1'b1;
    bit          res_stalls_on  = 1'b1;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // floor(acc + 1/2) from q4.60 to q2.30, clipped to 32 bits
    function automatic t_q230 round_to_q230(input logic signed [65:0] acc);
        logic signed [65:0] q;
        t_q230              r;
        q = (acc + ROUND_BIAS) >>> 30;
        if (q > Q230_TOP) begin
            r.value   = tqdg_pkg::Q_MAX;
            r.clipped = 1'b1;
        end else if (q < Q230_FLOOR) begin
            r.value   = tqdg_pkg::Q_MIN;
            r.clipped = 1'b1;
        end else begin
            r.value   = q[31:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

    function automatic t_scaled_amp scale_amplitude(input logic signed [31:0] ar,
                                                    input logic signed [31:0] ai,
                                                    input logic last);
        logic [63:0]        gidx;
        logic               b1;
        logic               b2;
        logic [63:0]        entry;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic signed [65:0] acc;
        t_q230              part;
        t_scaled_amp        res;
        gidx = {32'd0, slice_base} + {32'd0, slice_pos};
        // bits at or above the index width read as zero, carry out included
        b1 = (first_bit_pos < tqdg_pkg::INDEX_BITS) ? gidx[first_bit_pos] : 1'b0;
        b2 = (second_bit_pos < tqdg_pkg::INDEX_BITS) ? gidx[second_bit_pos] : 1'b0;
        entry = gate_entry[{b1, b2}];
        cr = entry[63:32];
        ci = entry[31:0];
        acc = ar * cr - ai * ci;
        part = round_to_q230(acc);
        res.re      = part.value;
        res.clipped = part.clipped;
        acc = ar * ci + ai * cr;
        part = round_to_q230(acc);
        res.im      = part.value;
        res.clipped = res.clipped | part.clipped;
        res.last    = last;
        slice_pos = last ? 32'd0 : slice_pos + 32'd1;
        return res;
    endfunction

    function automatic logic [31:0] rand_q230();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'h4000_0000;
                    default: return 32'hC000_0000;
                endcase
            end
            // magnitude within one, as in a normalised state
            default: return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
        endcase
    endfunction

    task automatic load_reg(input logic [tqdg_pkg::CFG_IDX_W-1:0] idx,
                            input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            tqdg_pkg::CFG_COEFF_00, tqdg_pkg::CFG_COEFF_01,
            tqdg_pkg::CFG_COEFF_10, tqdg_pkg::CFG_COEFF_11:
                gate_entry[idx[1:0]] = data;
            tqdg_pkg::CFG_FIRST_POS:  first_bit_pos  = data[4:0];
            tqdg_pkg::CFG_SECOND_POS: second_bit_pos = data[4:0];
            tqdg_pkg::CFG_BASE_INDEX: slice_base     = data[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_amp(input logic [31:0] re, input logic [31:0] im, input logic last);
        int n;
        n = pick_gap(amp_gaps_on);
        repeat (n) begin
            @(negedge i_clk);
            amp_ch.valid    <= 1'b0;
            amp_ch.amp_re   <= $urandom;
            amp_ch.amp_im   <= $urandom;
            amp_ch.last_amp <= 1'($urandom_range(0, 1));
        end
        @(negedge i_clk);
        amp_ch.valid    <= 1'b1;
        amp_ch.amp_re   <= re;
        amp_ch.amp_im   <= im;
        amp_ch.last_amp <= last;
        do @(posedge i_clk); while (!(amp_ch.valid && amp_ch.ready));
    endtask

    // block is idle once every beat is back and the pipeline has settled
    task automatic flush_pipeline();
        @(negedge i_clk);
        amp_ch.valid <= 1'b0;
        while (pending_amps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        // every entry is i after reset
        send_amp(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_amp(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_amp(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_amp(32'h4000_0000, 32'hC000_0000, 1'b1);
        flush_pipeline();
    endtask

    task automatic test_rounding_saturation();
        load_reg(tqdg_pkg::CFG_COEFF_00, {32'h2000_0000, 32'h0000_0000});
        load_reg(tqdg_pkg::CFG_COEFF_01, {32'h8000_0000, 32'h8000_0000});
        load_reg(tqdg_pkg::CFG_COEFF_10, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        load_reg(tqdg_pkg::CFG_COEFF_11, {32'h8000_0000, 32'h7FFF_FFFF});
        // half-lsb ties round up, on both signs, then a sum that saturates
        send_amp(32'd1, 32'hFFFF_FFFF, 1'b0);
        send_amp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        // sum of products beyond the 64-bit range, then more half-lsb ties
        send_amp(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_amp(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_amp(32'd3, 32'hFFFF_FFFD, 1'b0);
        send_amp(32'h8000_0000, 32'h0000_0000, 1'b1);
        flush_pipeline();
    endtask

    task automatic test_entry_select();
        int k;
        load_reg(tqdg_pkg::CFG_COEFF_00, {32'h4000_0000, 32'h0000_0000});
        load_reg(tqdg_pkg::CFG_COEFF_01, {32'h0000_0000, 32'h4000_0000});
        load_reg(tqdg_pkg::CFG_COEFF_10, {32'hC000_0000, 32'h0000_0000});
        load_reg(tqdg_pkg::CFG_COEFF_11, {32'h0000_0000, 32'hC000_0000});
        // same bit for both qubits, global index wraps mid-slice
        load_reg(tqdg_pkg::CFG_FIRST_POS, {$urandom, $urandom & 32'hFFFF_FFE0} | 64'd3);
        load_reg(tqdg_pkg::CFG_SECOND_POS, {$urandom, $urandom & 32'hFFFF_FFE0} | 64'd3);
        load_reg(tqdg_pkg::CFG_BASE_INDEX, {$urandom, 32'hFFFF_FFFC});
        for (k = 0; k < 8; k++)
            send_amp($urandom, $urandom, k == 7);
        flush_pipeline();
        load_reg(CFG_NO_REG, {$urandom, $urandom});
        load_reg(tqdg_pkg::CFG_FIRST_POS, 64'd31);
        load_reg(tqdg_pkg::CFG_SECOND_POS, 64'd0);
        load_reg(tqdg_pkg::CFG_BASE_INDEX, 64'h0000_0000_7FFF_FFFE);
        for (k = 0; k < 4; k++)
            send_amp($urandom, $urandom, k == 3);
        flush_pipeline();
    endtask

    task automatic test_random_slices();
        int          phase;
        int          sent;
        int          len;
        int          k;
        bit          noisy;
        logic [4:0]  p1;
        logic [4:0]  p2;
        logic [31:0] base;
        for (phase = 0; phase < PHASES; phase++) begin
            amp_gaps_on   = (phase != 0) && (phase != 2);
            res_stalls_on = (phase >= 2);
            case (phase)
                0: begin p1 = 5'd0;  p2 = 5'd31; base = 32'd0; end
                1: begin p1 = 5'd31; p2 = 5'd31; base = 32'hFFFF_FFFF - $urandom_range(0, 64); end
                2: begin p1 = 5'd0;  p2 = 5'd0;  base = $urandom; end
                default: begin
                    p1 = 5'($urandom_range(0, 31));
                    p2 = $urandom_range(0, 2) == 0 ? p1 : 5'($urandom_range(0, 31));
                    case ($urandom_range(0, 2))
                        0: base = 32'd0;
                        1: base = 32'hFFFF_FFFF - $urandom_range(0, 300);
                        default: base = $urandom;
                    endcase
                end
            endcase
            load_reg(tqdg_pkg::CFG_COEFF_00, {rand_q230(), rand_q230()});
            load_reg(tqdg_pkg::CFG_COEFF_01, {rand_q230(), rand_q230()});
            load_reg(tqdg_pkg::CFG_COEFF_10, {rand_q230(), rand_q230()});
            load_reg(tqdg_pkg::CFG_COEFF_11, {rand_q230(), rand_q230()});
            load_reg(tqdg_pkg::CFG_FIRST_POS, {$urandom, $urandom & 32'hFFFF_FFE0} | 64'(p1));
            load_reg(tqdg_pkg::CFG_SECOND_POS, {$urandom, $urandom & 32'hFFFF_FFE0} | 64'(p2));
            load_reg(tqdg_pkg::CFG_BASE_INDEX, {$urandom, base});
            if ($urandom_range(0, 1) == 1)
                load_reg(CFG_NO_REG, {$urandom, $urandom});
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                  : $urandom_range(1, 24);
                noisy = ($urandom_range(0, 6) == 0);
                // the slice open at the end of a phase runs on into the next one
                for (k = 0; k < len && sent < ITEMS_PER_PHASE; k++) begin
                    send_amp(rand_q230(), rand_q230(),
                             noisy ? 1'($urandom_range(0, 1)) : (k == len - 1));
                    sent++;
                end
            end
            flush_pipeline();
        end
    endtask

    // result checker: each beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_amps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat at %0t: re %h im %h last %b sat %b",
                                 $time, res_ch.out_re, res_ch.out_im, res_ch.out_last,
                                 res_ch.saturated);
                end else begin
                    want_amp = pending_amps.pop_front();
                    if (res_ch.out_re !== want_amp.re || res_ch.out_im !== want_amp.im ||
                        res_ch.out_last !== want_amp.last ||
                        res_ch.saturated !== want_amp.clipped) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result mismatch at %0t: want re %h im %h last %b sat %b",
                                     $time, want_amp.re, want_amp.im, want_amp.last,
                                     want_amp.clipped);
                            $display("    got re %h im %h last %b sat %b",
                                     res_ch.out_re, res_ch.out_im, res_ch.out_last,
                                     res_ch.saturated);
                        end
                    end
                end
            end
            if (amp_ch.valid && amp_ch.ready)
                pending_amps.push_back(scale_amplitude(amp_ch.amp_re, amp_ch.amp_im,
                                                       amp_ch.last_amp));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("two_qubit_diagonal_gate_apply verification failed");
            $finish;
        end
    end

    initial begin : res_ready_drive
        int n;
        res_ch.ready = 1'b0;
        forever begin
            n = pick_gap(res_stalls_on);
            repeat (n) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        amp_ch.valid    = 1'b0;
        amp_ch.amp_re   = '0;
        amp_ch.amp_im   = '0;
        amp_ch.last_amp = 1'b0;
        for (int k = 0; k < 4; k++)
            gate_entry[k] = tqdg_pkg::COEFF_RESET;
        first_bit_pos  = tqdg_pkg::FIRST_POS_RESET;
        second_bit_pos = tqdg_pkg::SECOND_POS_RESET;
        slice_base     = '0;
        slice_pos      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_rounding_saturation();
        test_entry_select();
        test_random_slices();

        if (mismatch_count == 0 && pending_amps.size() == 0) begin
            $display("two_qubit_diagonal_gate_apply verification clean");
        end else begin
            $display("two_qubit_diagonal_gate_apply verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/tqdg_pkg.sv
src/tqdg_amp_if.sv
src/tqdg_res_if.sv
src/tqdg_front.sv
src/tqdg_queue.sv
src/tqdg_back.sv
src/two_qubit_diagonal_gate_apply.sv
tb/two_qubit_diagonal_gate_apply_test.sv
